// File: rtl/resp_request_parser_assert.svh
// Assertion macros used by the parser top level.
// In synthesis builds the macros expand to nothing.
`ifndef RESP_REQUEST_PARSER_ASSERT_SVH
`define RESP_REQUEST_PARSER_ASSERT_SVH

`ifndef SYNTH

// cond must imply prop in the same cycle
`define RRP_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rrp assertion failed");

// expr must never be true
`define RRP_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rrp assertion failed");

`else

`define RRP_ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define RRP_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// File: rtl/rrp_pkg.sv
`timescale 1ns / 1ps

package rrp_pkg;

  localparam int ARG_W = 17;
  localparam int CFG_W = 32;
  localparam int Q_DEPTH = 2;

  // event codes on the result channel
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PAYLOAD  = 2'd1;
  localparam logic [1:0] EV_ARG_DONE = 2'd2;
  localparam logic [1:0] EV_ERROR    = 2'd3;

  // configuration register indexes
  localparam logic CFG_MAX_ARG_COUNT = 1'b0;
  localparam logic CFG_MAX_VALUE_LEN = 1'b1;

  localparam logic [ARG_W-1:0] MAX_ARG_COUNT_RST = 17'd100000;
  localparam logic [CFG_W-1:0] MAX_VALUE_LEN_RST = 32'd1048576;

  // header length limits, in bytes before the CR
  localparam logic [3:0] CNT_HDR_MAX = 4'd9;
  localparam logic [3:0] LEN_HDR_MAX = 4'd12;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // one stream byte with its character class
  typedef struct packed {
    logic [7:0] data;
    logic       is_star;
    logic       is_dollar;
    logic       is_cr;
    logic       is_lf;
    logic       is_minus;
    logic       is_zero;
    logic       is_digit;
    logic [3:0] digit;
  } byte_class_t;

endpackage

// File: rtl/rrp_front.sv
`timescale 1ns / 1ps

module rrp_front import rrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        push_valid,
  input  logic        push_ready,
  output byte_class_t push_item
);

  logic        held;
  byte_class_t item;
  byte_class_t cls;

  always_comb begin
    cls.data      = in_byte;
    cls.is_star   = (in_byte == CH_STAR);
    cls.is_dollar = (in_byte == CH_DOLLAR);
    cls.is_cr     = (in_byte == CH_CR);
    cls.is_lf     = (in_byte == CH_LF);
    cls.is_minus  = (in_byte == CH_MINUS);
    cls.is_zero   = (in_byte == CH_ZERO);
    cls.is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    cls.digit     = in_byte[3:0];
  end

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= cls;
    end
  end

endmodule

// File: rtl/rrp_queue.sv
`timescale 1ns / 1ps

module rrp_queue import rrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  byte_class_t push_item,
  output logic        pop_valid,
  input  logic        pop_ready,
  output byte_class_t pop_item
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  byte_class_t mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = (count != CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/rrp_back.sv
`timescale 1ns / 1ps

module rrp_back import rrp_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  byte_class_t      item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       event_kind,
  output logic [7:0]       payload_byte,
  output logic [ARG_W-1:0] arg_index,
  output logic             command_done,
  output logic [ARG_W-1:0] arg_total
);

  localparam int LB = LENGTH_BITS;
  localparam int XW = LB + 4;
  localparam int CW = (LB > CFG_W) ? LB : CFG_W;
  localparam logic [LB-1:0] ACC_MAX = {LB{1'b1}};

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_CNT_HDR    = 4'd1;
  localparam logic [3:0] PH_CNT_LF     = 4'd2;
  localparam logic [3:0] PH_ARG_DOLLAR = 4'd3;
  localparam logic [3:0] PH_LEN_HDR    = 4'd4;
  localparam logic [3:0] PH_LEN_LF     = 4'd5;
  localparam logic [3:0] PH_PAYLOAD    = 4'd6;
  localparam logic [3:0] PH_SKIP_A     = 4'd7;
  localparam logic [3:0] PH_SKIP_B     = 4'd8;

  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_DASH = 2'd1;
  localparam logic [1:0] EM_ZERO = 2'd2;

  logic [ARG_W-1:0] max_arg_count;
  logic [CFG_W-1:0] max_value_len;

  logic [3:0]       phase, phase_next;
  logic [ARG_W-1:0] declared_args, declared_args_next;
  logic [ARG_W-1:0] args_seen, args_seen_next;
  logic [LB-1:0]    acc, acc_next;
  logic [3:0]       hdr_cnt, hdr_cnt_next;
  logic [LB-1:0]    payload_left, payload_left_next;
  logic [1:0]       empty_marker, empty_marker_next;

  logic [1:0]       ev;
  logic [7:0]       pb;
  logic             done;
  logic             err;
  logic             do_finish;

  logic [XW-1:0]    acc_x10;
  logic [LB-1:0]    acc_dig;
  logic             count_bad;
  logic             len_bad;
  logic [LB-1:0]    pl_dec;
  logic [ARG_W-1:0] seen_inc;
  logic             pop;

  assign item_ready = !out_valid || out_ready;
  assign pop        = item_valid && item_ready;

  // acc * 10 + digit, saturating at all ones
  assign acc_x10 = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + XW'(item.digit);
  assign acc_dig = (acc_x10[XW-1:LB] != 4'b0000) ? ACC_MAX : acc_x10[LB-1:0];

  assign count_bad = (acc == '0) || (acc == ACC_MAX) || (CW'(acc) > CW'(max_arg_count));
  assign len_bad   = (acc == '0) || (acc == ACC_MAX) || (CW'(acc) >= CW'(max_value_len));
  assign pl_dec    = payload_left - LB'(1);
  assign seen_inc  = args_seen + ARG_W'(1);

  always_comb begin
    phase_next         = phase;
    declared_args_next = declared_args;
    args_seen_next     = args_seen;
    acc_next           = acc;
    hdr_cnt_next       = hdr_cnt;
    payload_left_next  = payload_left;
    empty_marker_next  = empty_marker;
    ev                 = EV_NONE;
    pb                 = 8'h00;
    done               = 1'b0;
    err                = 1'b0;
    do_finish          = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.is_star) begin
          phase_next        = PH_CNT_HDR;
          acc_next          = '0;
          hdr_cnt_next      = 4'd0;
          empty_marker_next = EM_NONE;
        end else if (item.is_dollar) begin
          // bare dollar: a one-argument command
          declared_args_next = ARG_W'(1);
          args_seen_next     = '0;
          phase_next         = PH_LEN_HDR;
          acc_next           = '0;
          hdr_cnt_next       = 4'd0;
          empty_marker_next  = EM_NONE;
        end else begin
          err = 1'b1;
        end
      end
      PH_CNT_HDR: begin
        if (item.is_cr) begin
          if (hdr_cnt == 4'd0) begin
            err = 1'b1;
          end else begin
            phase_next = PH_CNT_LF;
          end
        end else if (!item.is_digit || hdr_cnt >= CNT_HDR_MAX) begin
          err = 1'b1;
        end else begin
          hdr_cnt_next = hdr_cnt + 4'd1;
          acc_next     = acc_dig;
        end
      end
      PH_CNT_LF: begin
        if (!item.is_lf || count_bad) begin
          err = 1'b1;
        end else begin
          declared_args_next = ARG_W'(acc);
          args_seen_next     = '0;
          phase_next         = PH_ARG_DOLLAR;
        end
      end
      PH_ARG_DOLLAR: begin
        if (item.is_dollar) begin
          phase_next        = PH_LEN_HDR;
          acc_next          = '0;
          hdr_cnt_next      = 4'd0;
          empty_marker_next = EM_NONE;
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_HDR: begin
        if (item.is_cr) begin
          if (hdr_cnt == 4'd0) begin
            err = 1'b1;
          end else begin
            phase_next = PH_LEN_LF;
          end
        end else if (hdr_cnt >= LEN_HDR_MAX) begin
          err = 1'b1;
        end else if (hdr_cnt == 4'd0 && (item.is_minus || item.is_zero)) begin
          empty_marker_next = item.is_minus ? EM_DASH : EM_ZERO;
          hdr_cnt_next      = hdr_cnt + 4'd1;
        end else if (empty_marker != EM_NONE) begin
          // empty form: ignore the rest of the header
          hdr_cnt_next = hdr_cnt + 4'd1;
        end else if (!item.is_digit) begin
          err = 1'b1;
        end else begin
          hdr_cnt_next = hdr_cnt + 4'd1;
          acc_next     = acc_dig;
        end
      end
      PH_LEN_LF: begin
        if (!item.is_lf) begin
          err = 1'b1;
        end else if (empty_marker == EM_DASH) begin
          do_finish = 1'b1;
        end else if (empty_marker == EM_ZERO) begin
          phase_next = PH_SKIP_A;
        end else if (len_bad) begin
          err = 1'b1;
        end else begin
          payload_left_next = acc;
          phase_next        = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ev                = EV_PAYLOAD;
        pb                = item.data;
        payload_left_next = pl_dec;
        if (pl_dec == '0) begin
          phase_next = PH_SKIP_A;
        end
      end
      PH_SKIP_A: begin
        phase_next = PH_SKIP_B;
      end
      PH_SKIP_B: begin
        do_finish = 1'b1;
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (do_finish) begin
      ev                = EV_ARG_DONE;
      args_seen_next    = seen_inc;
      empty_marker_next = EM_NONE;
      if (seen_inc >= declared_args) begin
        done               = 1'b1;
        phase_next         = PH_IDLE;
        declared_args_next = '0;
        args_seen_next     = '0;
        acc_next           = '0;
        hdr_cnt_next       = 4'd0;
        payload_left_next  = '0;
      end else begin
        phase_next = PH_ARG_DOLLAR;
      end
    end

    if (err) begin
      ev                 = EV_ERROR;
      pb                 = 8'h00;
      done               = 1'b0;
      phase_next         = PH_IDLE;
      declared_args_next = '0;
      args_seen_next     = '0;
      acc_next           = '0;
      hdr_cnt_next       = 4'd0;
      payload_left_next  = '0;
      empty_marker_next  = EM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_count <= MAX_ARG_COUNT_RST;
      max_value_len <= MAX_VALUE_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_ARG_COUNT: max_arg_count <= cfg_data[ARG_W-1:0];
        CFG_MAX_VALUE_LEN: max_value_len <= cfg_data;
        default:           max_value_len <= max_value_len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      declared_args <= '0;
      args_seen     <= '0;
      acc           <= '0;
      hdr_cnt       <= 4'd0;
      payload_left  <= '0;
      empty_marker  <= EM_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        declared_args <= declared_args_next;
        args_seen     <= args_seen_next;
        acc           <= acc_next;
        hdr_cnt       <= hdr_cnt_next;
        payload_left  <= payload_left_next;
        empty_marker  <= empty_marker_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word, loaded together with the state update
  always_ff @(posedge clk) begin
    if (pop) begin
      event_kind   <= ev;
      payload_byte <= pb;
      arg_index    <= args_seen;
      command_done <= done;
      arg_total    <= declared_args;
    end
  end

endmodule

// File: rtl/resp_request_parser.sv
`timescale 1ns / 1ps
// RESP request parser. Takes the request stream one byte per word on the in
// channel and gives one result word per byte on the out channel: nothing,
// a payload byte, an argument complete (with command_done on the last one) or
// a protocol error, after which the parser is back in idle. arg_index and
// arg_total show the argument counters as they stood before the byte. The
// sustained rate is one byte per cycle while out_ready stays high; between a
// byte and its result lie the input classify register, the two-word queue and
// the result register, and the rate rests on the parser state update for each
// byte, whose longest path is the saturating multiply-by-ten accumulate. The
// cfg channel is always ready; index 0 writes max_arg_count, index 1 writes
// max_value_len, and writes take effect on the next byte. No clearing pass
// follows reset.
`include "resp_request_parser_assert.svh"

module resp_request_parser import rrp_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       event_kind,
  output logic [7:0]       payload_byte,
  output logic [ARG_W-1:0] arg_index,
  output logic             command_done,
  output logic [ARG_W-1:0] arg_total
);

  logic        push_valid;
  logic        push_ready;
  byte_class_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  byte_class_t pop_item;

  assign cfg_ready = 1'b1;

  rrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  rrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  rrp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (pop_valid),
    .item_ready   (pop_ready),
    .item         (pop_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .payload_byte (payload_byte),
    .arg_index    (arg_index),
    .command_done (command_done),
    .arg_total    (arg_total)
  );

  `RRP_ASSERT_IMPLIES(a_done_on_arg, clk, rst, out_valid && command_done, event_kind == EV_ARG_DONE)
  `RRP_ASSERT_IMPLIES(a_byte_only_payload, clk, rst, out_valid && event_kind != EV_PAYLOAD, payload_byte == 8'h00)
  `RRP_ASSERT_IMPLIES(a_index_in_range, clk, rst, out_valid, arg_index <= arg_total)
  `RRP_ASSERT_NEVER(a_no_pop_on_stall, clk, rst, pop_valid && pop_ready && out_valid && !out_ready)

endmodule

// File: dv/rrp_checker.sv
`timescale 1ns / 1ps

module rrp_checker import rrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       event_kind,
  input  logic [7:0]       payload_byte,
  input  logic [ARG_W-1:0] arg_index,
  input  logic             command_done,
  input  logic [ARG_W-1:0] arg_total,
  output int               fail_count,
  output int               pending
);

  localparam logic [CFG_W-1:0] ACC_SAT = '1;

  typedef enum logic [3:0] {
    PS_IDLE,
    PS_COUNT,
    PS_COUNT_LF,
    PS_NEXT_ARG,
    PS_LENGTH,
    PS_LENGTH_LF,
    PS_DATA,
    PS_TRAIL_1,
    PS_TRAIL_2
  } parse_state_e;

  typedef enum logic [1:0] {
    EMPTY_NONE,
    EMPTY_NIL,
    EMPTY_ZERO
  } empty_form_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [ARG_W-1:0] index;
    logic             done;
    logic [ARG_W-1:0] total;
  } parse_event_t;

  parse_state_e     ps;
  empty_form_e      empty_form;
  logic [ARG_W-1:0] args_declared;
  logic [ARG_W-1:0] args_done;
  logic [ARG_W-1:0] lim_args;
  logic [CFG_W-1:0] acc;
  logic [CFG_W-1:0] data_left;
  logic [CFG_W-1:0] lim_len;
  logic [3:0]       hdr_len;
  parse_event_t     expected_events[$];
  parse_event_t     next_ev;
  parse_event_t     want_ev;

  initial fail_count = 0;

  function automatic void clear_parser();
    ps = PS_IDLE;
    args_declared = '0;
    args_done = '0;
    acc = '0;
    hdr_len = '0;
    data_left = '0;
    empty_form = EMPTY_NONE;
  endfunction

  function automatic void open_header(input parse_state_e nxt);
    ps = nxt;
    acc = '0;
    hdr_len = '0;
    empty_form = EMPTY_NONE;
  endfunction

  // saturate at all ones instead of wrapping
  function automatic logic [CFG_W-1:0] times_ten_plus(input logic [CFG_W-1:0] a,
                                                      input logic [3:0] d);
    longint unsigned wide;
    wide = 64'(a) * 10 + 64'(d);
    if (wide > 64'(ACC_SAT)) return ACC_SAT;
    return wide[CFG_W-1:0];
  endfunction

  function automatic logic finish_arg();
    args_done = args_done + 1'b1;
    empty_form = EMPTY_NONE;
    if (args_done >= args_declared) begin
      clear_parser();
      return 1'b1;
    end
    ps = PS_NEXT_ARG;
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, output parse_event_t ev);
    logic is_digit;
    logic failed;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    failed = 1'b0;
    ev = '0;
    ev.kind = EV_NONE;
    ev.index = args_done;
    ev.total = args_declared;
    case (ps)
      PS_IDLE: begin
        if (b == CH_STAR) begin
          open_header(PS_COUNT);
        end else if (b == CH_DOLLAR) begin
          // bare dollar: a one-argument command
          args_declared = ARG_W'(1);
          args_done = '0;
          open_header(PS_LENGTH);
        end else begin
          failed = 1'b1;
        end
      end
      PS_COUNT: begin
        if (b == CH_CR) begin
          if (hdr_len == 0) failed = 1'b1;
          else ps = PS_COUNT_LF;
        end else if (!is_digit || hdr_len >= CNT_HDR_MAX) begin
          failed = 1'b1;
        end else begin
          hdr_len++;
          acc = times_ten_plus(acc, b[3:0]);
        end
      end
      PS_COUNT_LF: begin
        if (b != CH_LF || acc == 0 || acc == ACC_SAT || acc > lim_args) begin
          failed = 1'b1;
        end else begin
          args_declared = acc[ARG_W-1:0];
          args_done = '0;
          ps = PS_NEXT_ARG;
        end
      end
      PS_NEXT_ARG: begin
        if (b == CH_DOLLAR) open_header(PS_LENGTH);
        else failed = 1'b1;
      end
      PS_LENGTH: begin
        if (b == CH_CR) begin
          if (hdr_len == 0) failed = 1'b1;
          else ps = PS_LENGTH_LF;
        end else if (hdr_len >= LEN_HDR_MAX) begin
          failed = 1'b1;
        end else if (hdr_len == 0 && (b == CH_MINUS || b == CH_ZERO)) begin
          empty_form = (b == CH_MINUS) ? EMPTY_NIL : EMPTY_ZERO;
          hdr_len++;
        end else if (empty_form != EMPTY_NONE) begin
          // empty form: skip anything up to the CR
          hdr_len++;
        end else if (!is_digit) begin
          failed = 1'b1;
        end else begin
          hdr_len++;
          acc = times_ten_plus(acc, b[3:0]);
        end
      end
      PS_LENGTH_LF: begin
        if (b != CH_LF) begin
          failed = 1'b1;
        end else if (empty_form == EMPTY_NIL) begin
          ev.kind = EV_ARG_DONE;
          ev.done = finish_arg();
        end else if (empty_form == EMPTY_ZERO) begin
          ps = PS_TRAIL_1;
        end else if (acc == 0 || acc == ACC_SAT || acc >= lim_len) begin
          failed = 1'b1;
        end else begin
          data_left = acc;
          ps = PS_DATA;
        end
      end
      PS_DATA: begin
        ev.kind = EV_PAYLOAD;
        ev.data = b;
        if (data_left != 0) data_left--;
        if (data_left == 0) ps = PS_TRAIL_1;
      end
      PS_TRAIL_1: ps = PS_TRAIL_2;
      PS_TRAIL_2: begin
        ev.kind = EV_ARG_DONE;
        ev.done = finish_arg();
      end
      default: failed = 1'b1;
    endcase
    if (failed) begin
      ev.kind = EV_ERROR;
      ev.data = '0;
      ev.done = 1'b0;
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lim_args = MAX_ARG_COUNT_RST;
      lim_len = MAX_VALUE_LEN_RST;
      clear_parser();
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_ARG_COUNT) lim_args = cfg_data[ARG_W-1:0];
        else lim_len = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t ns: result with nothing expected, event_kind expected none, got %0d",
                   $time, event_kind);
          fail_count++;
        end else begin
          want_ev = expected_events.pop_front();
          check_field("event_kind", want_ev.kind, event_kind);
          check_field("payload_byte", want_ev.data, payload_byte);
          check_field("arg_index", want_ev.index, arg_index);
          check_field("command_done", want_ev.done, command_done);
          check_field("arg_total", want_ev.total, arg_total);
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_byte, next_ev);
        expected_events.insert(expected_events.size(), next_ev);
      end
    end
    pending <= expected_events.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top import rrp_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int BLOCK_BYTES = 305;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 150;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = CFG_MAX_ARG_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       event_kind;
  logic [7:0]       payload_byte;
  logic [ARG_W-1:0] arg_index;
  logic             command_done;
  logic [ARG_W-1:0] arg_total;

  int fail_count;
  int pending;
  int tx_idle_pct = 36;
  int rx_idle_pct = 72;
  int results_seen;
  int hold_left;
  int cycles = 0;

  int               cur_max_args = MAX_ARG_COUNT_RST;
  longint unsigned  cur_max_len = MAX_VALUE_LEN_RST;
  logic [7:0]       stream[$];

  resp_request_parser u_dut (.*);

  rrp_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      results_seen <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) results_seen <= results_seen + 1;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (out_valid && out_ready && results_seen == HOLD_AT) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // append one byte to the outgoing stream
  function automatic void add_byte(input logic [7:0] b);
    stream.insert(stream.size(), b);
  endfunction

  function automatic logic [7:0] any_byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == a || v == b);
    return v;
  endfunction

  function automatic logic [7:0] non_digit(input logic [7:0] also_not);
    logic [7:0] v;
    do v = 8'($urandom_range(255));
    while ((v >= CH_ZERO && v <= CH_NINE) || v == CH_CR || v == also_not);
    return v;
  endfunction

  function automatic logic [7:0] rand_digit(input int lo);
    return CH_ZERO + 8'($urandom_range(9, lo));
  endfunction

  task automatic push_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic push_dec(input longint unsigned v);
    logic [7:0]      digits[$];
    longint unsigned rest;
    rest = v;
    do begin
      digits.push_front(CH_ZERO + 8'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    foreach (digits[i]) add_byte(digits[i]);
  endtask

  // the two bytes after a payload are not checked by the parser
  task automatic push_trailer();
    if ($urandom_range(9) < 7) begin
      push_crlf();
    end else begin
      add_byte(8'($urandom_range(255)));
      add_byte(8'($urandom_range(255)));
    end
  endtask

  // one argument after its '$'
  task automatic push_arg_body();
    int pick;
    int len_cap;
    int len;
    pick = $urandom_range(99);
    if (pick < 12) begin
      add_byte(CH_MINUS);
      repeat ($urandom_range(10)) add_byte(any_byte_except(CH_CR, CH_CR));
      push_crlf();
    end else if (pick < 24) begin
      add_byte(CH_ZERO);
      repeat ($urandom_range(3)) add_byte(any_byte_except(CH_CR, CH_CR));
      push_crlf();
      push_trailer();
    end else begin
      len_cap = ($urandom_range(9) == 0) ? 48 : 10;
      if (cur_max_len - 1 < len_cap) len_cap = int'(cur_max_len - 1);
      len = $urandom_range(len_cap, 1);
      push_dec(len);
      push_crlf();
      repeat (len) add_byte(8'($urandom_range(255)));
      push_trailer();
    end
  endtask

  task automatic push_command();
    int n;
    int top_n;
    int zeros;
    if ($urandom_range(3) == 0) begin
      add_byte(CH_DOLLAR);
      push_arg_body();
    end else begin
      top_n = (cur_max_args < 4) ? cur_max_args : 4;
      n = $urandom_range(top_n, 1);
      zeros = ($urandom_range(4) == 0) ? $urandom_range(8, 1) : 0;
      add_byte(CH_STAR);
      repeat (zeros) add_byte(CH_ZERO);
      push_dec(n);
      push_crlf();
      repeat (n) begin
        add_byte(CH_DOLLAR);
        push_arg_body();
      end
    end
  endtask

  task automatic push_broken();
    int              pick;
    int              n;
    int              top_n;
    longint unsigned over;
    pick = $urandom_range(11);
    top_n = (cur_max_args < 4) ? cur_max_args : 4;
    case (pick)
      0: add_byte(any_byte_except(CH_STAR, CH_DOLLAR));
      1: begin
        add_byte($urandom_range(1) ? CH_STAR : CH_DOLLAR);
        add_byte(CH_CR);
      end
      2: begin
        add_byte(CH_STAR);
        repeat ($urandom_range(3)) add_byte(rand_digit(0));
        add_byte(non_digit(CH_CR));
      end
      3: begin
        add_byte(CH_DOLLAR);
        if ($urandom_range(1)) begin
          add_byte(non_digit(CH_MINUS));
        end else begin
          add_byte(rand_digit(1));
          repeat ($urandom_range(2)) add_byte(rand_digit(0));
          add_byte(non_digit(CH_CR));
        end
      end
      4: begin
        add_byte(CH_STAR);
        repeat (10) add_byte(rand_digit(0));
      end
      5: begin
        add_byte(CH_DOLLAR);
        if ($urandom_range(1)) begin
          add_byte(CH_MINUS);
          repeat (12) add_byte(any_byte_except(CH_CR, CH_CR));
        end else begin
          add_byte(rand_digit(1));
          repeat (12) add_byte(rand_digit(0));
        end
      end
      6: begin
        add_byte($urandom_range(1) ? CH_STAR : CH_DOLLAR);
        push_dec(1);
        add_byte(CH_CR);
        add_byte(any_byte_except(CH_LF, CH_LF));
      end
      7: begin
        add_byte(CH_STAR);
        repeat ($urandom_range(4, 1)) add_byte(CH_ZERO);
        push_crlf();
      end
      8: begin
        add_byte(CH_STAR);
        push_dec(cur_max_args + 1);
        push_crlf();
      end
      9: begin
        over = cur_max_len + $urandom_range(2);
        if (over > 64'hFFFF_FFFF) over = 64'hFFFF_FFFF;
        add_byte(CH_DOLLAR);
        push_dec(over);
        push_crlf();
      end
      10: begin
        // enough nines to saturate the length accumulator
        add_byte(CH_DOLLAR);
        repeat ($urandom_range(12, 11)) add_byte(CH_NINE);
        push_crlf();
      end
      default: begin
        if (cur_max_args < 2) begin
          add_byte(any_byte_except(CH_STAR, CH_DOLLAR));
        end else begin
          n = ($urandom_range(3) == 0) ? cur_max_args : $urandom_range(top_n, 2);
          add_byte(CH_STAR);
          push_dec(n);
          push_crlf();
          add_byte(CH_DOLLAR);
          push_arg_body();
          add_byte(any_byte_except(CH_DOLLAR, CH_DOLLAR));
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // send everything queued, then wait until every result is back
  task automatic send_stream();
    foreach (stream[i]) send_byte(stream[i]);
    stream.delete();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_block();
    int pick;
    while (stream.size() < BLOCK_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        push_command();
      end else if (pick < 85) begin
        push_broken();
      end else begin
        repeat ($urandom_range(4, 1)) add_byte(8'($urandom_range(255)));
      end
    end
    send_stream();
  endtask

  task automatic write_limits(input int args_lim, input logic [CFG_W-1:0] len_lim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_ARG_COUNT;
    cfg_data <= CFG_W'(args_lim);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MAX_VALUE_LEN;
    cfg_data <= len_lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_max_args = args_lim;
    cur_max_len = len_lim;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bad leads at both byte extremes, empty header, bare dollar, both empty forms
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_STAR);
    add_byte(CH_CR);
    add_byte(CH_DOLLAR);
    push_dec(1);
    push_crlf();
    add_byte(8'hFF);
    push_crlf();
    add_byte(CH_STAR);
    push_dec(2);
    push_crlf();
    add_byte(CH_DOLLAR);
    add_byte(CH_MINUS);
    push_dec(1);
    push_crlf();
    add_byte(CH_DOLLAR);
    add_byte(CH_ZERO);
    push_crlf();
    push_crlf();
    send_stream();

    random_block();
    write_limits(1, 2);
    random_block();

    tx_idle_pct = 72;
    rx_idle_pct = 36;
    write_limits(131071, '1);
    random_block();
    write_limits($urandom_range(6, 2), $urandom_range(20, 3));
    random_block();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_limits($urandom_range(131070, 3), $urandom_range(100000, 8));
    random_block();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
